// ----- hw/rtl/running_stats_accumulator_macros.svh -----
// assertion macros shared by the running statistics checker
`ifndef RUNNING_STATS_ACCUMULATOR_MACROS_SVH
`define RUNNING_STATS_ACCUMULATOR_MACROS_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define RSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define RSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rsa_pkg.sv -----
// shared types and constants of the running statistics accumulator
package rsa_pkg;

  localparam int SAMPLE_BITS_DEF    = 31;
  localparam int MEAN_FRAC_BITS_DEF = 16;
  localparam int VAR_BITS           = 64;
  localparam int COUNT_BITS         = 32;

  // item kinds carried on tuser
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_MERGE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV_MEAN,
    ST_SQUARE,
    ST_ADD_SQ,
    ST_DIV_VAR,
    ST_DONE
  } state_e;

endpackage

// ----- hw/rtl/running_stats_accumulator.sv -----
// running minimum, peak, count, mean and variance of unsigned samples
//
// input channel s_axis: one item is either a new sample (tuser low) or a
// statistics record to merge in (tuser high); tdata carries sample, other
// minimum, peak, mean, variance and count. output channel m_axis: one item
// per input item with the statistics after the update.
// the work is bit serial: a shift-add pass forms mean*n and var*n
// together, one restoring divider makes one quotient bit a cycle,
// and the squared deviation comes from a second shift-add pass
//   add sample:    shift-add, divide mean, square, add square, divide var
//   merge record:  shift-add, divide mean, divide var
//   empty merge:   straight to done (counts sum to zero, mean and variance kept)
// each then returns to idle before the next item is taken
// the result sits in an output register, so a new item is accepted while
// it waits; a finished item holds in the done state until that register
// is free, so a stalled receiver stalls the input after at most one item
// reset: minimum all ones, peak, mean, variance and count zero, no result
module running_stats_accumulator #(
  parameter int SAMPLE_BITS    = rsa_pkg::SAMPLE_BITS_DEF,
  parameter int MEAN_FRAC_BITS = rsa_pkg::MEAN_FRAC_BITS_DEF,
  localparam int MB       = SAMPLE_BITS + MEAN_FRAC_BITS,
  localparam int IN_BITS  = 3 * SAMPLE_BITS + MB + rsa_pkg::VAR_BITS + rsa_pkg::COUNT_BITS,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 2 * SAMPLE_BITS + MB + rsa_pkg::VAR_BITS + rsa_pkg::COUNT_BITS,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // sample, other_minimum, other_peak, other_mean, other_variance, other_count
  input  logic [IN_W-1:0]  s_axis_tdata,
  // op
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // minimum, peak, mean, variance, count
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int S      = SAMPLE_BITS;
  localparam int F      = MEAN_FRAC_BITS;
  localparam int VB     = rsa_pkg::VAR_BITS;
  localparam int CB     = rsa_pkg::COUNT_BITS;
  localparam int DIV_W  = CB + 1;                          // n+1 or n+m
  localparam int ACCM_W = (MB + DIV_W > 2 * MB) ? MB + DIV_W : 2 * MB;
  localparam int ACCV_W = VB + DIV_W;
  localparam int MUL_W  = (MB > CB) ? MB : CB;
  localparam int STEP_W = $clog2(VB);

  // input field offsets, lowest first
  localparam int IN_OMIN  = S;
  localparam int IN_OPK   = 2 * S;
  localparam int IN_OMEAN = 3 * S;
  localparam int IN_OVAR  = 3 * S + MB;
  localparam int IN_OCNT  = 3 * S + MB + VB;

  // fields of the input item
  logic          in_op;
  logic [S-1:0]  in_sample;
  logic [S-1:0]  in_omin;
  logic [S-1:0]  in_opk;
  logic [MB-1:0] in_omean;
  logic [VB-1:0] in_ovar;
  logic [CB-1:0] in_ocnt;

  assign in_op     = s_axis_tuser;
  assign in_sample = s_axis_tdata[0 +: S];
  assign in_omin   = s_axis_tdata[IN_OMIN +: S];
  assign in_opk    = s_axis_tdata[IN_OPK +: S];
  assign in_omean  = s_axis_tdata[IN_OMEAN +: MB];
  assign in_ovar   = s_axis_tdata[IN_OVAR +: VB];
  assign in_ocnt   = s_axis_tdata[IN_OCNT +: CB];

  // control
  rsa_pkg::state_e   state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              merge_q, merge_d;
  logic              out_valid_q, out_valid_d;

  // running statistics
  logic [S-1:0]  min_q, min_d;
  logic [S-1:0]  peak_q, peak_d;
  logic [MB-1:0] mean_q, mean_d;
  logic [VB-1:0] var_q, var_d;
  logic [CB-1:0] count_q, count_d;

  // operands and serial datapath
  logic [DIV_W-1:0]  div_q, div_d;        // divisor
  logic [MB-1:0]     bm_q, bm_d;          // other mean, scaled sample, then deviation
  logic [VB-1:0]     bv_q, bv_d;          // other variance, zero when adding
  logic [MUL_W-1:0]  mul_q, mul_d;        // n, then deviation, msb first
  logic [CB-1:0]     mulm_q, mulm_d;      // m, or one when adding
  logic [ACCM_W-1:0] accm_q, accm_d;
  logic [ACCV_W-1:0] accv_q, accv_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [VB-1:0]     dvd_q, dvd_d;        // dividend bits out on top, quotient in at bottom
  logic [OUT_W-1:0]  out_data_q, out_data_d;

  // strobes
  logic in_accept;
  logic out_load;
  logic step_last;

  // shared comb values
  logic [DIV_W-1:0]  tot;
  logic              empty_merge;
  logic [ACCM_W-1:0] mac_m_sum;
  logic [ACCV_W-1:0] mac_v_sum;
  logic [ACCM_W-1:0] sq_sum;
  logic [ACCV_W-1:0] accv_plus_sq;
  logic [DIV_W:0]    div_t;
  logic              div_ge;
  logic [DIV_W:0]    div_sub;
  logic [DIV_W-1:0]  div_rem;
  logic [VB-1:0]     div_dvd;
  logic [MB-1:0]     q_mean;
  logic [MB-1:0]     xs_dev;

  // ---------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------
  assign tot = {1'b0, count_q} + ((in_op == rsa_pkg::OP_MERGE) ? {1'b0, in_ocnt}
                                                               : DIV_W'(1));
  assign empty_merge = (in_op == rsa_pkg::OP_MERGE) && (tot == '0);
  assign step_last   = (cnt_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rsa_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = empty_merge ? rsa_pkg::ST_DONE : rsa_pkg::ST_MAC;
        end
      end
      rsa_pkg::ST_MAC: begin
        if (step_last) state_d = rsa_pkg::ST_DIV_MEAN;
      end
      rsa_pkg::ST_DIV_MEAN: begin
        if (step_last) state_d = merge_q ? rsa_pkg::ST_DIV_VAR : rsa_pkg::ST_SQUARE;
      end
      rsa_pkg::ST_SQUARE: begin
        if (step_last) state_d = rsa_pkg::ST_ADD_SQ;
      end
      rsa_pkg::ST_ADD_SQ: begin
        state_d = rsa_pkg::ST_DIV_VAR;
      end
      rsa_pkg::ST_DIV_VAR: begin
        if (step_last) state_d = rsa_pkg::ST_DONE;
      end
      rsa_pkg::ST_DONE: begin
        if (out_load) state_d = rsa_pkg::ST_IDLE;
      end
      default: state_d = rsa_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // handshake outputs and strobes
  // ---------------------------------------------------------------------
  always_comb begin
    s_axis_tready = (state_q == rsa_pkg::ST_IDLE);
    in_accept     = s_axis_tvalid && s_axis_tready;
    // a finished item moves to the output register once it is free
    out_load      = (state_q == rsa_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------
  // serial arithmetic
  // ---------------------------------------------------------------------
  // msb-first shift-add: mean*n + b*m and var*n + ovar*m in one pass
  assign mac_m_sum = (accm_q << 1)
                   + (mul_q[MUL_W-1] ? ACCM_W'(mean_q) : '0)
                   + (mulm_q[CB-1]   ? ACCM_W'(bm_q)   : '0);
  assign mac_v_sum = (accv_q << 1)
                   + (mul_q[MUL_W-1] ? ACCV_W'(var_q) : '0)
                   + (mulm_q[CB-1]   ? ACCV_W'(bv_q)  : '0);

  // squaring pass of the deviation held in bm_q
  assign sq_sum = (accm_q << 1) + (mul_q[MUL_W-1] ? ACCM_W'(bm_q) : '0);

  // var*n plus the squared deviation with its fraction dropped
  assign accv_plus_sq = accv_q + ACCV_W'(accm_q >> (2 * F));

  // restoring divider step, one quotient bit a cycle
  assign div_t   = {rem_q, dvd_q[VB-1]};
  assign div_sub = div_t - {1'b0, div_q};
  assign div_ge  = (div_t >= {1'b0, div_q});
  assign div_rem = div_ge ? div_sub[DIV_W-1:0] : div_t[DIV_W-1:0];
  assign div_dvd = {dvd_q[VB-2:0], div_ge};

  // new mean and distance of the scaled sample from it
  assign q_mean = div_dvd[MB-1:0];
  assign xs_dev = (bm_q >= q_mean) ? (bm_q - q_mean) : (q_mean - bm_q);

  always_comb begin
    cnt_d       = cnt_q;
    merge_d     = merge_q;
    min_d       = min_q;
    peak_d      = peak_q;
    mean_d      = mean_q;
    var_d       = var_q;
    count_d     = count_q;
    div_d       = div_q;
    bm_d        = bm_q;
    bv_d        = bv_q;
    mul_d       = mul_q;
    mulm_d      = mulm_q;
    accm_d      = accm_q;
    accv_d      = accv_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    unique case (state_q)
      rsa_pkg::ST_IDLE: begin
        if (in_accept) begin
          merge_d = in_op;
          div_d   = tot;
          cnt_d   = STEP_W'(CB - 1);
          mul_d   = MUL_W'(count_q) << (MUL_W - CB);
          accm_d  = '0;
          accv_d  = '0;
          if (in_op == rsa_pkg::OP_MERGE) begin
            mulm_d = in_ocnt;
            bm_d   = in_omean;
            bv_d   = in_ovar;
            if (in_omin < min_q) min_d = in_omin;
            if (in_opk > peak_q) peak_d = in_opk;
          end else begin
            // the sample enters the mean pass as x*2^F times one
            mulm_d = CB'(1);
            bm_d   = MB'(in_sample) << F;
            bv_d   = '0;
            if (in_sample < min_q) min_d = in_sample;
            if (in_sample > peak_q) peak_d = in_sample;
          end
          // count saturates, the divisor keeps the true sum
          count_d = tot[CB] ? '1 : tot[CB-1:0];
        end
      end
      rsa_pkg::ST_MAC: begin
        accm_d = mac_m_sum;
        accv_d = mac_v_sum;
        mul_d  = mul_q << 1;
        mulm_d = mulm_q << 1;
        cnt_d  = cnt_q - 1'b1;
        if (step_last) begin
          // quotient fits MB bits, so the high part starts below the divisor
          rem_d = mac_m_sum[MB +: DIV_W];
          dvd_d = VB'(mac_m_sum[MB-1:0]) << (VB - MB);
          cnt_d = STEP_W'(MB - 1);
        end
      end
      rsa_pkg::ST_DIV_MEAN: begin
        rem_d = div_rem;
        dvd_d = div_dvd;
        cnt_d = cnt_q - 1'b1;
        if (step_last) begin
          mean_d = q_mean;
          if (merge_q) begin
            rem_d = accv_q[VB +: DIV_W];
            dvd_d = accv_q[VB-1:0];
            cnt_d = STEP_W'(VB - 1);
          end else begin
            bm_d   = xs_dev;
            mul_d  = MUL_W'(xs_dev) << (MUL_W - MB);
            accm_d = '0;
            cnt_d  = STEP_W'(MB - 1);
          end
        end
      end
      rsa_pkg::ST_SQUARE: begin
        accm_d = sq_sum;
        mul_d  = mul_q << 1;
        cnt_d  = cnt_q - 1'b1;
      end
      rsa_pkg::ST_ADD_SQ: begin
        rem_d = accv_plus_sq[VB +: DIV_W];
        dvd_d = accv_plus_sq[VB-1:0];
        cnt_d = STEP_W'(VB - 1);
      end
      rsa_pkg::ST_DIV_VAR: begin
        rem_d = div_rem;
        dvd_d = div_dvd;
        cnt_d = cnt_q - 1'b1;
        if (step_last) var_d = div_dvd;
      end
      rsa_pkg::ST_DONE: begin
        if (out_load) begin
          out_data_d  = OUT_W'({count_q, var_q, mean_q, peak_q, min_q});
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsa_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      min_q       <= '1;
      peak_q      <= '0;
      mean_q      <= '0;
      var_q       <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      min_q       <= min_d;
      peak_q      <= peak_d;
      mean_q      <= mean_d;
      var_q       <= var_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    merge_q    <= merge_d;
    div_q      <= div_d;
    bm_q       <= bm_d;
    bv_q       <= bv_d;
    mul_q      <= mul_d;
    mulm_q     <= mulm_d;
    accm_q     <= accm_d;
    accv_q     <= accv_d;
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    out_data_q <= out_data_d;
  end

endmodule

// ----- hw/rtl/rsa_checker.sv -----
// port-level checks of the running statistics accumulator and their binding
`include "running_stats_accumulator_macros.svh"

module rsa_checker #(
  parameter int SAMPLE_BITS    = rsa_pkg::SAMPLE_BITS_DEF,
  parameter int MEAN_FRAC_BITS = rsa_pkg::MEAN_FRAC_BITS_DEF,
  localparam int MB       = SAMPLE_BITS + MEAN_FRAC_BITS,
  localparam int IN_BITS  = 3 * SAMPLE_BITS + MB + rsa_pkg::VAR_BITS + rsa_pkg::COUNT_BITS,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 2 * SAMPLE_BITS + MB + rsa_pkg::VAR_BITS + rsa_pkg::COUNT_BITS,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [IN_W-1:0]  s_axis_tdata,
  input logic             s_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  localparam int OUT_MEAN = 2 * SAMPLE_BITS;
  localparam int OUT_VAR  = OUT_MEAN + MB;
  localparam int OUT_CNT  = OUT_VAR + rsa_pkg::VAR_BITS;

  logic s_acc;
  logic empty_stats;

  assign s_acc       = s_axis_tvalid && s_axis_tready;
  assign empty_stats = (m_axis_tdata[OUT_CNT +: rsa_pkg::COUNT_BITS] == '0);

  // a stalled result holds
  `RSA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // one item at a time: busy right after an accept
  `RSA_ASSERT_NEXT(a_busy_after_accept, s_acc, !s_axis_tready,
                   "input taken again right after an accept")

  // no result appears in the cycle right after an accept
  `RSA_ASSERT_NEXT(a_no_instant_result, s_acc, !$rose(m_axis_tvalid),
                   "result appeared without any work time")

  // with no samples recorded, mean and variance stay at zero
  `RSA_ASSERT_NOW(a_empty_stats_zero, m_axis_tvalid && empty_stats,
                  (m_axis_tdata[OUT_MEAN +: MB] == '0) &&
                  (m_axis_tdata[OUT_VAR +: rsa_pkg::VAR_BITS] == '0),
                  "nonzero mean or variance with zero count")

  logic unused_in;
  assign unused_in = ^{s_axis_tdata, s_axis_tuser};

endmodule

bind running_stats_accumulator rsa_checker #(
  .SAMPLE_BITS    (SAMPLE_BITS),
  .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
) u_rsa_checker (.*);

// ----- test/running_stats_accumulator_tb.sv -----
// testbench of the running statistics accumulator: directed table, then random items
module running_stats_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB       = rsa_pkg::SAMPLE_BITS_DEF;
  localparam int FB       = rsa_pkg::MEAN_FRAC_BITS_DEF;
  localparam int MB       = SB + FB;
  localparam int IN_BITS  = 3 * SB + MB + rsa_pkg::VAR_BITS + rsa_pkg::COUNT_BITS;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 * SB + MB + rsa_pkg::VAR_BITS + rsa_pkg::COUNT_BITS;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [63:0] MEAN_LIM  = (64'd1 << MB) - 64'd1;
  localparam logic [63:0] VAR_LIM   = 64'hffff_ffff_ffff_ffff;
  localparam logic [31:0] COUNT_LIM = 32'hffff_ffff;
  localparam logic [SB-1:0] SMP_MAX = '1;

  // long enough to cover one add item still in flight
  localparam int TAIL_CYCLES  = 256;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 200;  // per idling phase, three phases

  // one input item, fields as the block sees them
  typedef struct packed {
    logic          op;
    logic [SB-1:0] sample;
    logic [SB-1:0] o_min;
    logic [SB-1:0] o_peak;
    logic [MB-1:0] o_mean;
    logic [63:0]   o_var;
    logic [31:0]   o_count;
  } stats_item_t;

  // one result item
  typedef struct packed {
    logic [SB-1:0] minimum;
    logic [SB-1:0] peak;
    logic [MB-1:0] mean;
    logic [63:0]   variance;
    logic [31:0]   count;
  } stats_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  running_stats_accumulator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor state, mirrors the block's registers
  logic [SB-1:0] acc_min   = '1;
  logic [SB-1:0] acc_peak  = '0;
  logic [MB-1:0] acc_mean  = '0;
  logic [63:0]   acc_var   = '0;
  logic [31:0]   acc_count = '0;

  // results still to come, oldest first
  stats_t pending_stats[$];

  // directed table
  stats_item_t dir_stim[$];
  stats_t      dir_want[$];
  bit          dir_typed[$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int mismatches   = 0;
  int cycles       = 0;

  // floor division, clipped to the register's range
  function automatic logic [63:0] quot_clip(logic [127:0] num, logic [127:0] den,
                                            logic [63:0] lim);
    logic [127:0] q;
    q = num / den;
    return (q > {64'd0, lim}) ? lim : q[63:0];
  endfunction

  // advance the running statistics by one item and return what the block should show
  function automatic stats_t stats_update(stats_item_t it);
    logic [127:0] n, m, tot, xs, d, sq;
    stats_t r;
    n = 128'(acc_count);
    if (it.op == rsa_pkg::OP_ADD) begin
      // the divisor is the true n+1, even with a saturated count
      xs = 128'(it.sample) << FB;
      tot = n + 128'd1;
      acc_mean = MB'(quot_clip(n * 128'(acc_mean) + xs, tot, MEAN_LIM));
      // deviation taken from the freshly truncated mean
      d = (xs >= 128'(acc_mean)) ? xs - 128'(acc_mean) : 128'(acc_mean) - xs;
      sq = (d * d) >> (2 * FB);
      acc_var = quot_clip(n * 128'(acc_var) + sq, tot, VAR_LIM);
      if (it.sample > acc_peak) acc_peak = it.sample;
      if (it.sample < acc_min) acc_min = it.sample;
    end else begin
      m = 128'(it.o_count);
      tot = n + m;
      // with no samples on either side mean and variance stay as they are
      if (tot != 128'd0) begin
        acc_mean = MB'(quot_clip(n * 128'(acc_mean) + m * 128'(it.o_mean), tot, MEAN_LIM));
        acc_var = quot_clip(n * 128'(acc_var) + m * 128'(it.o_var), tot, VAR_LIM);
      end
      if (it.o_peak > acc_peak) acc_peak = it.o_peak;
      if (it.o_min < acc_min) acc_min = it.o_min;
    end
    acc_count = (tot > 128'(COUNT_LIM)) ? COUNT_LIM : tot[31:0];
    r.minimum = acc_min;
    r.peak = acc_peak;
    r.mean = acc_mean;
    r.variance = acc_var;
    r.count = acc_count;
    return r;
  endfunction

  // tdata from the lowest bit up: sample, other minimum, peak, mean, variance, count
  function automatic logic [IN_W-1:0] pack_item(stats_item_t it);
    return IN_W'({it.o_count, it.o_var, it.o_mean, it.o_peak, it.o_min, it.sample});
  endfunction

  // tdata from the lowest bit up: minimum, peak, mean, variance, count
  function automatic stats_t unpack_stats(logic [OUT_W-1:0] d);
    stats_t s;
    s.minimum = d[SB-1:0];
    s.peak = d[2*SB-1:SB];
    s.mean = d[2*SB+MB-1:2*SB];
    s.variance = d[2*SB+MB+63:2*SB+MB];
    s.count = d[2*SB+MB+95:2*SB+MB+64];
    return s;
  endfunction

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s at cycle %0d: expected %h, actual %h", what, cycles, want, got);
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) note_mismatch(what, want, got);
  endfunction

  // result side: check every accepted item, then pick the next ready value
  always @(posedge clk_i) begin : result_sink
    stats_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = unpack_stats(m_axis_tdata);
      if (pending_stats.size() == 0) begin
        note_mismatch("result with nothing pending", '0, 64'(got.count));
      end else begin
        want = pending_stats.pop_front();
        check_field("minimum", 64'(want.minimum), 64'(got.minimum));
        check_field("peak", 64'(want.peak), 64'(got.peak));
        check_field("mean", 64'(want.mean), 64'(got.mean));
        check_field("variance", want.variance, got.variance);
        check_field("count", 64'(want.count), 64'(got.count));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // present one item, wait for its handshake, then record what it should produce;
  // valid stays high into the next call unless the sender decides to idle
  task automatic send_item(stats_item_t it, bit typed, stats_t want);
    stats_t predicted;
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.op;
    s_axis_tdata <= pack_item(it);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // predictor always runs so its state follows the block, typed rows override
    predicted = stats_update(it);
    pending_stats.push_back(typed ? want : predicted);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_stats.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(logic op, logic [SB-1:0] smp, logic [SB-1:0] omin,
                         logic [SB-1:0] opk, logic [MB-1:0] omean, logic [63:0] ovar,
                         logic [31:0] ocnt, bit typed, stats_t want);
    stats_item_t it;
    it.op = op;
    it.sample = smp;
    it.o_min = omin;
    it.o_peak = opk;
    it.o_mean = omean;
    it.o_var = ovar;
    it.o_count = ocnt;
    dir_stim.push_back(it);
    dir_typed.push_back(typed);
    dir_want.push_back(want);
  endtask

  // samples spread over magnitudes, with the extremes now and then
  function automatic logic [SB-1:0] rand_sample();
    case ($urandom_range(3))
      0: return SB'($urandom);
      1: return SB'($urandom_range(255));
      2: return $urandom_range(1) ? SMP_MAX : '0;
      default: return SB'($urandom) >> $urandom_range(SB - 1);
    endcase
  endfunction

  function automatic stats_item_t rand_item();
    stats_item_t it;
    it.op = ($urandom_range(99) < 40) ? rsa_pkg::OP_MERGE : rsa_pkg::OP_ADD;
    it.sample = rand_sample();
    it.o_min = rand_sample();
    it.o_peak = rand_sample();
    it.o_mean = MB'({$urandom, $urandom}) >> $urandom_range(MB - 1);
    it.o_var = {$urandom, $urandom} >> $urandom_range(63);
    case ($urandom_range(3))
      0: it.o_count = '0;
      1: it.o_count = 32'($urandom_range(1000, 1));
      2: it.o_count = $urandom;
      default: it.o_count = COUNT_LIM;
    endcase
    return it;
  endfunction

  initial begin
    // directed table; unused operand fields carry junk that must be ignored
    // empty merge straight after reset: shows the reset values, nothing to weight
    add_row(rsa_pkg::OP_MERGE, 31'h2a5a5a5a, SMP_MAX, '0, MB'(MEAN_LIM), VAR_LIM, '0,
            1'b1, stats_t'({SMP_MAX, 31'd0, 47'd0, 64'd0, 32'd0}));
    // empty merge still takes the extremes
    add_row(rsa_pkg::OP_MERGE, SMP_MAX, 31'd1000, 31'd5000, 47'd12345, 64'd999, '0, 1'b1,
            stats_t'({31'd1000, 31'd5000, 47'd0, 64'd0, 32'd0}));
    // first sample: mean is the sample itself, no spread
    add_row(rsa_pkg::OP_ADD, 31'd100, 31'h1234567, 31'h7654321, MB'(MEAN_LIM), VAR_LIM,
            COUNT_LIM, 1'b1, stats_t'({31'd100, 31'd5000, 47'd6553600, 64'd0, 32'd1}));
    // merge with zero weight leaves mean and variance alone
    add_row(rsa_pkg::OP_MERGE, SMP_MAX, 31'd2000, 31'd3000, MB'(MEAN_LIM), VAR_LIM, '0,
            1'b1, stats_t'({31'd100, 31'd5000, 47'd6553600, 64'd0, 32'd1}));
    add_row(rsa_pkg::OP_ADD, '0, SMP_MAX, SMP_MAX, '0, '0, '0, 1'b0, '0);
    add_row(rsa_pkg::OP_ADD, SMP_MAX, '0, '0, MB'(MEAN_LIM), VAR_LIM, COUNT_LIM, 1'b0, '0);
    add_row(rsa_pkg::OP_ADD, 31'd12345, '0, '0, '0, '0, '0, 1'b0, '0);
    add_row(rsa_pkg::OP_MERGE, '0, 31'd50, 31'd60, MB'(MEAN_LIM), VAR_LIM, 32'd1, 1'b0, '0);
    add_row(rsa_pkg::OP_MERGE, SMP_MAX, '0, SMP_MAX, '0, '0, 32'd3, 1'b0, '0);
    add_row(rsa_pkg::OP_ADD, SMP_MAX, 31'h0f0f0f0f, 31'h70f0f0f0, 47'h5555_5555_5555,
            64'd7, '0, 1'b0, '0);
    add_row(rsa_pkg::OP_MERGE, 31'd77, SMP_MAX, '0, 47'd1 << 30, 64'd1 << 40, 32'd100,
            1'b0, '0);
    // counts that sum past the top: count sticks at all ones
    add_row(rsa_pkg::OP_MERGE, '0, SMP_MAX, '0, MB'(MEAN_LIM), VAR_LIM, COUNT_LIM,
            1'b0, '0);
    // saturated count, divisor is the true n+1
    add_row(rsa_pkg::OP_ADD, '0, SMP_MAX, SMP_MAX, MB'(MEAN_LIM), VAR_LIM, COUNT_LIM,
            1'b0, '0);
    add_row(rsa_pkg::OP_ADD, SMP_MAX, '0, '0, '0, '0, '0, 1'b0, '0);
    add_row(rsa_pkg::OP_MERGE, SMP_MAX, SMP_MAX, '0, '0, '0, COUNT_LIM, 1'b0, '0);
    add_row(rsa_pkg::OP_MERGE, 31'd5, 31'd9, 31'd9, MB'(MEAN_LIM), VAR_LIM, '0, 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first phase: sender mostly busy, receiver mostly stalling
    src_idle_pct = 28;
    snk_idle_pct = 72;
    foreach (dir_stim[i]) send_item(dir_stim[i], dir_typed[i], dir_want[i]);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 28;
          snk_idle_pct = 72;
        end
        1: begin
          src_idle_pct = 72;
          snk_idle_pct = 28;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      repeat (RANDOM_ITEMS) send_item(rand_item(), 1'b0, '0);
      drain_results();
    end

    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
